/* hdl/bme_pkg.sv */
package bme_pkg;

  localparam int MAX_ROWS = 32;
  localparam int MAX_COLS = 32;
  localparam int ROW_IW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_IW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  typedef enum logic [2:0] {
    OP_SET_ROW     = 3'd0,
    OP_SET_CELL    = 3'd1,
    OP_GET_CELL    = 3'd2,
    OP_NEXT_IN_ROW = 3'd3,
    OP_NEXT_IN_COL = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_COL   = 2'd2,
    ST_ROW   = 2'd3
  } status_t;

  typedef enum logic {
    REG_NUM_ROWS = 1'b0,
    REG_NUM_COLS = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
  } dp_cmd_t;

  localparam logic [5:0] SIZE_RESET = 6'd32;
  localparam logic signed [5:0] NONE_FOUND = -6'sd2;

endpackage

/* hdl/bit_matrix_engine.sv */
// Boolean matrix of up to 32 x 32 cells held in flip-flops, one word per row.
// Each accepted beat runs one operation (set/clear row, set/clear cell, get
// cell, next set column in a row, next set row in a column) and returns one
// result beat. Each beat is first captured in the input registers; the block
// then reads the row word or gathers the selected column from every row,
// priority encodes, writes back and loads the output register, holding off
// while an earlier result waits on out_stall. The next beat is taken while a
// result still waits on out_stall. Writing num_rows or num_cols clears every
// cell in the same cycle; write them only while the block is idle.
module bit_matrix_engine (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        in_op,
  input  logic [4:0]        in_row,
  input  logic [4:0]        in_col,
  input  logic              in_value,
  input  logic signed [5:0] in_prev,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_bit_res,
  output logic signed [5:0] out_found,
  output logic [1:0]        out_status,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [5:0]        cfg_data
);
  import bme_pkg::*;

  dp_cmd_t cmd;

  bme_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  bme_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_op       (in_op),
    .in_row      (in_row),
    .in_col      (in_col),
    .in_value    (in_value),
    .in_prev     (in_prev),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .out_bit_res (out_bit_res),
    .out_found   (out_found),
    .out_status  (out_status)
  );

endmodule

/* hdl/bme_ctrl.sv */
module bme_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  output bme_pkg::dp_cmd_t cmd
);
  import bme_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!out_valid_r || !out_stall) begin
          cmd.exec  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (cmd.exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* hdl/bme_dp.sv */
module bme_dp (
  input  logic             clk,
  input  logic             rst_n,
  input  bme_pkg::dp_cmd_t cmd,
  input  logic [2:0]       in_op,
  input  logic [4:0]       in_row,
  input  logic [4:0]       in_col,
  input  logic             in_value,
  input  logic signed [5:0] in_prev,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [5:0]       cfg_data,
  output logic             out_bit_res,
  output logic signed [5:0] out_found,
  output logic [1:0]       out_status
);
  import bme_pkg::*;

  logic [MAX_COLS-1:0] cells_r [MAX_ROWS];
  logic [5:0]          num_rows_r, num_cols_r;
  logic [2:0]          op_r;
  logic [4:0]          row_r, col_r;
  logic                value_r;
  logic signed [5:0]   prev_r;
  logic                bit_res_r;
  logic signed [5:0]   found_r;
  logic [1:0]          status_r;

  op_t                 op_e;
  logic [5:0]          rows_use, cols_use, start;
  logic                use_row, use_col, search;
  status_t             status;
  logic [ROW_IW-1:0]   row_idx;
  logic [COL_IW-1:0]   col_idx;
  logic [MAX_COLS-1:0] row_word, row_hit, col_keep;
  logic [MAX_ROWS-1:0] col_hit;
  logic signed [5:0]   row_found, col_found;
  logic                clr;
  logic                wr_en;
  logic [MAX_COLS-1:0] wr_word;
  logic                bit_res_nxt;
  logic signed [5:0]   found_nxt;

  assign clr = cfg_we && (cfg_index == REG_NUM_ROWS || cfg_index == REG_NUM_COLS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_rows_r <= SIZE_RESET;
      num_cols_r <= SIZE_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_NUM_ROWS) begin
        num_rows_r <= cfg_data;
      end else begin
        num_cols_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      for (int r = 0; r < MAX_ROWS; r++) begin
        cells_r[r] <= '0;
      end
    end else if (wr_en) begin
      cells_r[row_idx] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_op;
      row_r   <= in_row;
      col_r   <= in_col;
      value_r <= in_value;
      prev_r  <= in_prev;
    end
    if (cmd.exec) begin
      bit_res_r <= bit_res_nxt;
      found_r   <= found_nxt;
      status_r  <= status;
    end
  end

  always_comb begin
    op_e     = op_t'(op_r);
    rows_use = (int'(num_rows_r) < MAX_ROWS) ? num_rows_r : 6'(MAX_ROWS);
    cols_use = (int'(num_cols_r) < MAX_COLS) ? num_cols_r : 6'(MAX_COLS);
    use_row  = (op_r <= OP_NEXT_IN_ROW);
    use_col  = (op_e == OP_SET_CELL) || (op_e == OP_GET_CELL) || (op_e == OP_NEXT_IN_COL);
    search   = (op_e == OP_NEXT_IN_ROW) || (op_e == OP_NEXT_IN_COL);
    row_idx  = ROW_IW'(row_r);
    col_idx  = COL_IW'(col_r);
    start    = prev_r[5] ? 6'd0 : 6'(prev_r) + 6'd1;

    priority if (rows_use == 6'd0 || cols_use == 6'd0) begin
      status = ST_EMPTY;
    end else if (use_col && {1'b0, col_r} >= cols_use) begin
      status = ST_COL;
    end else if (use_row && {1'b0, row_r} >= rows_use) begin
      status = ST_ROW;
    end else begin
      status = ST_OK;
    end

    row_word = cells_r[row_idx];
    for (int i = 0; i < MAX_COLS; i++) begin
      col_keep[i] = (i < int'(cols_use));
      row_hit[i]  = row_word[i] && col_keep[i] && (i >= int'(start));
    end
    for (int r = 0; r < MAX_ROWS; r++) begin
      col_hit[r] = cells_r[r][col_idx] && (r < int'(rows_use)) && (r >= int'(start));
    end

    row_found = NONE_FOUND;
    for (int i = MAX_COLS - 1; i >= 0; i--) begin
      if (row_hit[i]) begin
        row_found = 6'(i);
      end
    end
    col_found = NONE_FOUND;
    for (int r = MAX_ROWS - 1; r >= 0; r--) begin
      if (col_hit[r]) begin
        col_found = 6'(r);
      end
    end

    wr_en       = 1'b0;
    wr_word     = row_word;
    bit_res_nxt = 1'b0;
    found_nxt   = search ? NONE_FOUND : 6'sd0;
    if (status == ST_OK) begin
      unique case (op_e)
        OP_SET_ROW: begin
          wr_en   = cmd.exec;
          wr_word = value_r ? col_keep : '0;
        end
        OP_SET_CELL: begin
          wr_en            = cmd.exec;
          wr_word[col_idx] = value_r;
        end
        OP_GET_CELL:    bit_res_nxt = row_word[col_idx];
        OP_NEXT_IN_ROW: found_nxt   = row_found;
        OP_NEXT_IN_COL: found_nxt   = col_found;
        default: begin
          found_nxt = 6'sd0;
        end
      endcase
    end
    if (op_r > OP_NEXT_IN_COL) begin
      status    = ST_OK;
      found_nxt = 6'sd0;
    end
  end

  assign out_bit_res = bit_res_r;
  assign out_found   = found_r;
  assign out_status  = status_r;

endmodule

/* hdl/bme_checker.sv */
module bme_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic [2:0]        in_op,
  input logic [4:0]        in_row,
  input logic [4:0]        in_col,
  input logic              in_value,
  input logic signed [5:0] in_prev,
  input logic              out_valid,
  input logic              out_stall,
  input logic              out_bit_res,
  input logic signed [5:0] out_found,
  input logic [1:0]        out_status,
  input logic              cfg_we,
  input logic              cfg_index,
  input logic [5:0]        cfg_data
);
  import bme_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_found) && $stable(out_status)
      && $stable(out_bit_res))
    else $error("stalled result beat changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second beat taken before the first was processed");

  a_bit_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bit_res |-> out_status == ST_OK && out_found == 6'sd0)
    else $error("cell bit reported with failed status or search result");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

endmodule

bind bit_matrix_engine bme_checker u_bme_checker (.*);

/* verif/bme_result_monitor.sv */
`timescale 1ns / 1ps

module bme_result_monitor (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [2:0]        in_op,
  input  logic [4:0]        in_row,
  input  logic [4:0]        in_col,
  input  logic              in_value,
  input  logic signed [5:0] in_prev,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic              out_bit_res,
  input  logic signed [5:0] out_found,
  input  logic [1:0]        out_status,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [5:0]        cfg_data,
  output int                mismatches,
  output int                outstanding,
  output int                checked
);
  import bme_pkg::*;

  typedef struct packed {
    logic              bit_res;
    logic signed [5:0] found;
    logic [1:0]        status;
  } outcome_t;

  outcome_t          awaited_q[$];
  logic [MAX_COLS-1:0] cell_bits [MAX_ROWS];
  logic [5:0]        num_rows_reg;
  logic [5:0]        num_cols_reg;

  function automatic outcome_t apply_op(input logic [2:0] op, input logic [4:0] row,
                                        input logic [4:0] col, input logic value,
                                        input logic signed [5:0] prev);
    outcome_t res;
    int       rows;
    int       cols;
    int       first;
    logic     use_row;
    logic     use_col;
    logic     search;
    res     = '0;
    rows    = (num_rows_reg < MAX_ROWS) ? num_rows_reg : MAX_ROWS;
    cols    = (num_cols_reg < MAX_COLS) ? num_cols_reg : MAX_COLS;
    if (op > OP_NEXT_IN_COL) return res;
    use_row = (op <= OP_NEXT_IN_ROW);
    use_col = (op == OP_SET_CELL) || (op == OP_GET_CELL) || (op == OP_NEXT_IN_COL);
    search  = (op == OP_NEXT_IN_ROW) || (op == OP_NEXT_IN_COL);
    res.status = ST_OK;
    if (rows == 0 || cols == 0) res.status = ST_EMPTY;
    else if (use_col && col >= cols) res.status = ST_COL;
    else if (use_row && row >= rows) res.status = ST_ROW;
    if (res.status != ST_OK) begin
      res.found = search ? NONE_FOUND : '0;
      return res;
    end
    first = (prev < 0) ? 0 : int'(prev) + 1;
    case (op)
      OP_SET_ROW: begin
        for (int c = 0; c < MAX_COLS; c++) cell_bits[row][c] = value && (c < cols);
      end
      OP_SET_CELL: cell_bits[row][col] = value;
      OP_GET_CELL: res.bit_res = cell_bits[row][col];
      OP_NEXT_IN_ROW: begin
        res.found = NONE_FOUND;
        for (int i = cols - 1; i >= first; i--) if (cell_bits[row][i]) res.found = 6'(i);
      end
      default: begin
        res.found = NONE_FOUND;
        for (int i = rows - 1; i >= first; i--) if (cell_bits[i][col]) res.found = 6'(i);
      end
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    outcome_t want;
    outcome_t got;
    if (!rst_n) begin
      num_rows_reg = SIZE_RESET;
      num_cols_reg = SIZE_RESET;
      for (int r = 0; r < MAX_ROWS; r++) cell_bits[r] = '0;
      awaited_q.delete();
      mismatches = 0;
      checked    = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_NUM_ROWS) num_rows_reg = cfg_data;
        else num_cols_reg = cfg_data;
        for (int r = 0; r < MAX_ROWS; r++) cell_bits[r] = '0;
      end
      if (out_valid && !out_stall) begin
        got = '{out_bit_res, out_found, out_status};
        if (awaited_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result beat: bit %0b found %0d status %0d",
                     got.bit_res, got.found, got.status);
        end else begin
          want = awaited_q.pop_front();
          checked++;
          if (got.bit_res !== want.bit_res || got.found !== want.found ||
              got.status !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch on result %0d: expected bit %0b found %0d status %0d, got bit %0b found %0d status %0d",
                       checked, want.bit_res, want.found, want.status,
                       got.bit_res, got.found, got.status);
          end
        end
      end
      if (in_valid && !in_stall)
        awaited_q.push_back(apply_op(in_op, in_row, in_col, in_value, in_prev));
    end
    outstanding = awaited_q.size();
  end

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import bme_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 150;
  localparam int SETTLE_CYCLES  = 8;
  localparam int NUM_PHASES     = 10;
  localparam logic [2:0] FIRST_UNUSED_OP = 3'(OP_NEXT_IN_COL) + 3'd1;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic [2:0]        in_op     = '0;
  logic [4:0]        in_row    = '0;
  logic [4:0]        in_col    = '0;
  logic              in_value  = 1'b0;
  logic signed [5:0] in_prev   = '0;
  logic              out_stall = 1'b0;
  logic              cfg_we    = 1'b0;
  logic              cfg_index = REG_NUM_ROWS;
  logic [5:0]        cfg_data  = '0;
  wire               in_stall;
  wire               out_valid;
  wire               out_bit_res;
  wire signed [5:0]  out_found;
  wire [1:0]         out_status;

  int   idle_pct       = 0;
  int   stall_pct      = 0;
  logic pressure_armed = 1'b0;
  int   beats_sent     = 0;
  int   rows_now       = 32;
  int   cols_now       = 32;
  int   mismatches;
  int   outstanding;
  int   checked;

  bit_matrix_engine DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_op(in_op), .in_row(in_row),
    .in_col(in_col), .in_value(in_value), .in_prev(in_prev),
    .out_valid(out_valid), .out_stall(out_stall), .out_bit_res(out_bit_res),
    .out_found(out_found), .out_status(out_status),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  bme_result_monitor result_monitor (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_op(in_op), .in_row(in_row),
    .in_col(in_col), .in_value(in_value), .in_prev(in_prev),
    .out_valid(out_valid), .out_stall(out_stall), .out_bit_res(out_bit_res),
    .out_found(out_found), .out_status(out_status),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .outstanding(outstanding), .checked(checked)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // hold off the result side once for a long stretch so the block backs up
  initial begin
    int   hold_left;
    logic held;
    hold_left = 0;
    held      = 1'b0;
    forever begin
      @(negedge clk);
      if (pressure_armed && !held) begin
        hold_left = HOLD_CYCLES;
        held      = 1'b1;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("watchdog expired with %0d results outstanding", outstanding);
    $display("testbench failed");
    $finish;
  end

  task automatic send_beat(input logic [2:0] op, input logic [4:0] row, input logic [4:0] col,
                           input logic value, input logic signed [5:0] prev);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_op    <= op;
    in_row   <= row;
    in_col   <= col;
    in_value <= value;
    in_prev  <= prev;
    do @(posedge clk); while (in_stall);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_sizes(input int rows, input int cols);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= REG_NUM_ROWS;
    cfg_data  <= 6'(rows);
    @(negedge clk);
    cfg_index <= REG_NUM_COLS;
    cfg_data  <= 6'(cols);
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
    rows_now = rows;
    cols_now = cols;
  endtask

  task automatic random_beat();
    int          k;
    int          ru;
    int          cu;
    int          span;
    logic [2:0]  op;
    logic [4:0]  row;
    logic [4:0]  col;
    logic        value;
    logic signed [5:0] prev;
    ru = (rows_now < MAX_ROWS) ? rows_now : MAX_ROWS;
    cu = (cols_now < MAX_COLS) ? cols_now : MAX_COLS;
    k  = $urandom_range(99);
    if (k < 8) op = OP_SET_ROW;
    else if (k < 38) op = OP_SET_CELL;
    else if (k < 55) op = OP_GET_CELL;
    else if (k < 77) op = OP_NEXT_IN_ROW;
    else if (k < 94) op = OP_NEXT_IN_COL;
    else op = 3'($urandom_range(FIRST_UNUSED_OP, 7));
    row = (ru > 0 && $urandom_range(9) < 8) ? 5'($urandom_range(ru - 1)) : 5'($urandom);
    col = (cu > 0 && $urandom_range(9) < 8) ? 5'($urandom_range(cu - 1)) : 5'($urandom);
    if (op == OP_SET_ROW) value = ($urandom_range(3) == 0);
    else value = ($urandom_range(9) < 7);
    span = (op == OP_NEXT_IN_COL) ? ru : cu;
    if (span == 0) span = 31;
    k = $urandom_range(99);
    if (k < 30) prev = -6'sd1;
    else if (k < 42) prev = 6'($urandom);
    else prev = 6'(int'($urandom_range(span)) - 1);
    send_beat(op, row, col, value, prev);
  endtask

  initial begin
    int phase_rows [NUM_PHASES];
    int phase_cols [NUM_PHASES];
    int items;
    phase_rows = '{32, 1, 63, 10, 0, 5, 32, 17, 32, 24};
    phase_cols = '{32, 1, 63, 20, 32, 32, 3, 9, 0, 7};
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_beat(OP_GET_CELL, 0, 0, 1'b0, -6'sd1);
    send_beat(OP_NEXT_IN_ROW, 0, 0, 1'b0, -6'sd1);
    send_beat(OP_SET_CELL, 0, 31, 1'b1, -6'sd1);
    send_beat(OP_SET_CELL, 31, 0, 1'b1, -6'sd1);
    send_beat(OP_NEXT_IN_ROW, 0, 0, 1'b0, -6'sd1);
    send_beat(OP_NEXT_IN_ROW, 0, 0, 1'b0, 6'sd31);
    send_beat(OP_NEXT_IN_COL, 0, 0, 1'b0, -6'sd32);
    send_beat(OP_SET_ROW, 5, 0, 1'b1, -6'sd1);
    send_beat(OP_NEXT_IN_ROW, 5, 0, 1'b0, 6'sd30);
    send_beat(OP_GET_CELL, 5, 17, 1'b0, -6'sd1);
    send_beat(OP_NEXT_IN_COL, 0, 17, 1'b0, -6'sd1);
    send_beat(OP_SET_CELL, 5, 17, 1'b0, -6'sd1);
    send_beat(OP_GET_CELL, 5, 17, 1'b0, -6'sd1);
    send_beat(OP_SET_ROW, 5, 0, 1'b0, -6'sd1);
    send_beat(OP_NEXT_IN_ROW, 5, 0, 1'b0, -6'sd1);
    for (int u = FIRST_UNUSED_OP; u < 8; u++) send_beat(3'(u), 31, 31, 1'b1, 6'sd31);

    write_sizes(10, 20);
    send_beat(OP_GET_CELL, 15, 25, 1'b0, -6'sd1);
    send_beat(OP_SET_CELL, 15, 3, 1'b1, -6'sd1);
    send_beat(OP_NEXT_IN_COL, 0, 25, 1'b0, -6'sd1);
    send_beat(OP_SET_ROW, 9, 0, 1'b1, -6'sd1);
    send_beat(OP_NEXT_IN_ROW, 9, 0, 1'b0, 6'sd18);

    write_sizes(0, 20);
    send_beat(OP_NEXT_IN_ROW, 0, 0, 1'b0, -6'sd1);
    send_beat(FIRST_UNUSED_OP, 0, 0, 1'b0, -6'sd1);

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_sizes(phase_rows[p], phase_cols[p]);
      case (p % 4)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 86;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 86;
        end
        default: begin
          idle_pct  = 31;
          stall_pct = 31;
        end
      endcase
      if (p == 0) pressure_armed = 1'b1;
      items = (phase_rows[p] == 0 || phase_cols[p] == 0) ? 20 : 90;
      repeat (items) random_beat();
    end

    wait_drained();
    $display("sent %0d beats across %0d size settings, including empty, 1x1 and oversized",
             beats_sent, NUM_PHASES + 3);
    $display("checked %0d results under four idle mixes and one long output hold-off",
             checked);
    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("testbench failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/bme_pkg.sv
hdl/bme_ctrl.sv
hdl/bme_dp.sv
hdl/bit_matrix_engine.sv
hdl/bme_checker.sv
verif/bme_result_monitor.sv
verif/testbench.sv
